/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
// every property is clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define OZAP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define OZAP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define OZAP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ozap_pkg.sv */
package ozap_pkg;

    // default sizes
    localparam int FILTER_ORDER_DEF = 12;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEFF_WIDTH_DEF  = 20;

    // fixed datapath widths
    localparam int MAX_TAPS   = 12;
    localparam int TAP_IDX_W  = 4;
    localparam int SLOT_W     = 20;
    localparam int FRAC_BITS  = 14;
    localparam int HIST_W     = 32;
    localparam int MUL_B_W    = 20;
    localparam int PROD_W     = HIST_W + MUL_B_W;
    localparam int ACC_W      = PROD_W + 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int POLE_GAIN_W     = 20;
    localparam int ZERO_COEFF_W    = 18;
    localparam int ONE_ZERO_GAIN_W = 15;
    localparam int NUM_COEFF_REGS  = 4;

    localparam logic signed [POLE_GAIN_W-1:0]  POLE_GAIN_RST     = 20'sd16384;
    localparam logic signed [ZERO_COEFF_W-1:0] ZERO_COEFF_RST    = 18'sd16384;
    localparam logic [ONE_ZERO_GAIN_W-1:0]     ONE_ZERO_GAIN_RST = 15'd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLE_0_2      = 3'd0,
        REG_POLE_3_5      = 3'd1,
        REG_POLE_6_8      = 3'd2,
        REG_POLE_9_11     = 3'd3,
        REG_POLE_GAIN     = 3'd4,
        REG_ZERO_COEFF    = 3'd5,
        REG_ONE_ZERO_GAIN = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [HIST_W-1:0] val;
        logic                     clip;
    } sat_t;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'((64'sd1 <<< (HIST_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO     = -SAT_HI - ACC_W'(1);

    // floor(v / 2^14 + 1/2)
    function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ROUND_HALF;
        return t >>> FRAC_BITS;
    endfunction

    // clamp to the signed history width
    function automatic sat_t sat_hist(input logic signed [ACC_W-1:0] v);
        sat_t r;
        if (v > SAT_HI) begin
            r.val  = SAT_HI[HIST_W-1:0];
            r.clip = 1'b1;
        end else if (v < SAT_LO) begin
            r.val  = SAT_LO[HIST_W-1:0];
            r.clip = 1'b1;
        end else begin
            r.val  = v[HIST_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

/* rtl/ozap_ram.sv */
module ozap_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 12,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/one_zero_all_pole_filter_core.sv */
// an accepted word passes the scale, zero, one-zero, gain, tap and round states before
//   out_valid rises; a new word is taken only once the sequencer is back in idle, since
//   the one shared 32x20 multiplier takes the two one-zero products, the pole gain and
//   one history tap per cycle, fed by one read port of the history memory
// reset: configuration registers return to their defaults, the history reads as zero through one
//   valid bit per entry, so no clearing pass is run and a word is taken right away
module one_zero_all_pole_filter_core #(
    parameter int FILTER_ORDER = ozap_pkg::FILTER_ORDER_DEF,
    parameter int SAMPLE_WIDTH = ozap_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEFF_WIDTH  = ozap_pkg::COEFF_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
    // filtered output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    out_sample,
    output logic                              clipped,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [ozap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ozap_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

`include "assert_macros.svh"

    localparam int HIST_W    = ozap_pkg::HIST_W;
    localparam int MUL_B_W   = ozap_pkg::MUL_B_W;
    localparam int PROD_W    = ozap_pkg::PROD_W;
    localparam int ACC_W     = ozap_pkg::ACC_W;
    localparam int TAP_IDX_W = ozap_pkg::TAP_IDX_W;
    localparam int SLOT_W    = ozap_pkg::SLOT_W;
    localparam int PTR_W     = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
    localparam int CNT_W     = $clog2(FILTER_ORDER + 1);
    localparam int COEFF_SLOTS = 2 ** TAP_IDX_W;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FILTER_ORDER - 1);
    localparam logic [CNT_W-1:0] TAP_COUNT = CNT_W'(FILTER_ORDER);

    // output clamp bounds at the sample width
    localparam logic signed [HIST_W-1:0] OUT_MAX =
        HIST_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [HIST_W-1:0] OUT_MIN = -OUT_MAX - HIST_W'(1);

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,  // waiting for a word
        S_SCALE = 7'b0000010,  // sample times one-zero gain
        S_ZERO  = 7'b0000100,  // previous scaled sample times zero coefficient
        S_ONEZ  = 7'b0001000,  // one-zero sum, clear accumulator
        S_GAIN  = 7'b0010000,  // one-zero output times pole gain, first tap read
        S_TAPS  = 7'b0100000,  // one history tap per cycle through the mac
        S_ROUND = 7'b1000000   // round, write history, load output
    } state_t;

    state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ozap_pkg::CFG_DATA_W-1:0]             pole_coeff_reg [ozap_pkg::NUM_COEFF_REGS];
    logic signed [ozap_pkg::POLE_GAIN_W-1:0]     pole_gain_reg;
    logic signed [ozap_pkg::ZERO_COEFF_W-1:0]    zero_coeff_reg;
    logic [ozap_pkg::ONE_ZERO_GAIN_W-1:0]        one_zero_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ozap_pkg::NUM_COEFF_REGS; r++)
            begin
                pole_coeff_reg[r] <= '0;
            end
            pole_gain_reg     <= ozap_pkg::POLE_GAIN_RST;
            zero_coeff_reg    <= ozap_pkg::ZERO_COEFF_RST;
            one_zero_gain_reg <= ozap_pkg::ONE_ZERO_GAIN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ozap_pkg::REG_POLE_0_2:      pole_coeff_reg[0] <= cfg_wdata;
                ozap_pkg::REG_POLE_3_5:      pole_coeff_reg[1] <= cfg_wdata;
                ozap_pkg::REG_POLE_6_8:      pole_coeff_reg[2] <= cfg_wdata;
                ozap_pkg::REG_POLE_9_11:     pole_coeff_reg[3] <= cfg_wdata;
                ozap_pkg::REG_POLE_GAIN:
                    pole_gain_reg <= signed'(cfg_wdata[ozap_pkg::POLE_GAIN_W-1:0]);
                ozap_pkg::REG_ZERO_COEFF:
                    zero_coeff_reg <= signed'(cfg_wdata[ozap_pkg::ZERO_COEFF_W-1:0]);
                ozap_pkg::REG_ONE_ZERO_GAIN:
                    one_zero_gain_reg <= cfg_wdata[ozap_pkg::ONE_ZERO_GAIN_W-1:0];
                default: ;  // unknown index, write is dropped
            endcase
        end
    end

    // unpack the packed slots into one coefficient per tap, sign-extended
    logic signed [MUL_B_W-1:0] coeff_arr [COEFF_SLOTS];

    for (genvar t = 0; t < COEFF_SLOTS; t++)
    begin : g_coeff
        if (t < ozap_pkg::MAX_TAPS)
        begin : g_used
            assign coeff_arr[t] =
                MUL_B_W'(signed'(pole_coeff_reg[t / 3][SLOT_W * (t % 3) +: COEFF_WIDTH]));
        end
        else
        begin : g_unused
            assign coeff_arr[t] = '0;
        end
    end

    // ------------------------------------------------------------------
    // history memory: circular buffer, tap i lives at base + i
    // ------------------------------------------------------------------
    logic [PTR_W-1:0]        base_reg;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [CNT_W-1:0]        tap_cnt_reg;
    logic [FILTER_ORDER-1:0] hist_vld_reg;
    logic                    rd_pend_reg;    // read data arrives this cycle
    logic                    rd_vld_reg;     // that entry was ever written
    logic [TAP_IDX_W-1:0]    rd_tap_reg;     // tap of the pending read

    logic                    rd_issue;
    logic                    round_go;
    logic [PTR_W-1:0]        wr_ptr;
    logic [HIST_W-1:0]       ram_rd_data;

    assign rd_issue = ((state_reg == S_GAIN) || (state_reg == S_TAPS))
                    && (tap_cnt_reg < TAP_COUNT);
    // the newest value goes in just below the current base, over the oldest tap
    assign wr_ptr   = (base_reg == '0) ? PTR_LAST : base_reg - PTR_W'(1);

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [HIST_W-1:0]       prev_reg;     // last scaled sample
    logic signed [HIST_W-1:0]       scaled_reg;
    logic signed [HIST_W-1:0]       oz_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           acc_en_reg;
    logic                           acc_sub_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic                           clip_reg;

    logic signed [HIST_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    ozap_pkg::sat_t            scaled_sat;
    ozap_pkg::sat_t            oz_sat;
    ozap_pkg::sat_t            y_sat;
    logic signed [ACC_W-1:0]   oz_sum;
    logic signed [HIST_W-1:0]  y_out;
    logic                      out_clip;

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            S_SCALE:
            begin
                mul_a = HIST_W'(x_reg);
                mul_b = signed'(MUL_B_W'(one_zero_gain_reg));
            end
            S_ZERO:
            begin
                mul_a = prev_reg;
                mul_b = MUL_B_W'(zero_coeff_reg);
            end
            S_GAIN:
            begin
                mul_a = oz_reg;
                mul_b = MUL_B_W'(pole_gain_reg);
            end
            default:
            begin
                // history tap, unwritten entries read as zero
                mul_a = rd_vld_reg ? signed'(ram_rd_data) : '0;
                mul_b = coeff_arr[rd_tap_reg];
            end
        endcase
    end

    assign scaled_sat = ozap_pkg::sat_hist(ozap_pkg::round_frac(ACC_W'(prod_reg)));
    assign oz_sum     = ozap_pkg::round_frac(ACC_W'(prod_reg)) + ACC_W'(scaled_reg);
    assign oz_sat     = ozap_pkg::sat_hist(oz_sum);
    assign y_sat      = ozap_pkg::sat_hist(ozap_pkg::round_frac(acc_reg));

    always_comb
    begin
        if (y_sat.val > OUT_MAX)
        begin
            y_out    = OUT_MAX;
            out_clip = 1'b1;
        end
        else if (y_sat.val < OUT_MIN)
        begin
            y_out    = OUT_MIN;
            out_clip = 1'b1;
        end
        else
        begin
            y_out    = y_sat.val;
            out_clip = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_IDLE:
            begin
                x_reg <= in_sample;
            end
            S_ZERO:
            begin
                scaled_reg <= scaled_sat.val;
            end
            S_ONEZ:
            begin
                oz_reg  <= oz_sat.val;
                acc_reg <= '0;
            end
            default:
            begin
                if (acc_en_reg)
                begin
                    if (acc_sub_reg)
                    begin
                        acc_reg <= acc_reg - ACC_W'(prod_reg);
                    end
                    else
                    begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer and control
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic clipped_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign round_go = (state_reg == S_ROUND) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_SCALE;
            S_SCALE: state_next = S_ZERO;
            S_ZERO:  state_next = S_ONEZ;
            S_ONEZ:  state_next = S_GAIN;
            S_GAIN:  state_next = S_TAPS;
            S_TAPS:
                // all reads issued and the last one multiplied
                if ((tap_cnt_reg == TAP_COUNT) && !rd_pend_reg) state_next = S_ROUND;
            S_ROUND: if (round_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            base_reg     <= '0;
            rd_ptr_reg   <= '0;
            tap_cnt_reg  <= '0;
            hist_vld_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_tap_reg   <= '0;
            prev_reg     <= '0;
            acc_en_reg   <= 1'b0;
            acc_sub_reg  <= 1'b0;
            clip_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_issue;
            // gain product adds, tap products subtract
            acc_en_reg  <= (state_reg == S_GAIN) || rd_pend_reg;
            acc_sub_reg <= rd_pend_reg;

            if (state_reg == S_IDLE)
            begin
                clip_reg <= 1'b0;
            end
            if (state_reg == S_ZERO)
            begin
                clip_reg <= clip_reg | scaled_sat.clip;
            end
            if (state_reg == S_ONEZ)
            begin
                clip_reg    <= clip_reg | oz_sat.clip;
                prev_reg    <= scaled_reg;
                tap_cnt_reg <= '0;
                rd_ptr_reg  <= base_reg;
            end

            if (rd_issue)
            begin
                rd_vld_reg  <= hist_vld_reg[rd_ptr_reg];
                rd_tap_reg  <= TAP_IDX_W'(tap_cnt_reg);
                tap_cnt_reg <= tap_cnt_reg + CNT_W'(1);
                rd_ptr_reg  <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end

            if (round_go)
            begin
                base_reg             <= wr_ptr;
                hist_vld_reg[wr_ptr] <= 1'b1;
            end
        end
    end

    ozap_ram #(
        .WIDTH  (HIST_W),
        .DEPTH  (FILTER_ORDER),
        .ADDR_W (PTR_W)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (round_go),
        .wr_addr (wr_ptr),
        .wr_data (y_sat.val),
        .rd_en   (rd_issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // output register, parts the sequencer from the downstream stall
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (round_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (round_go)
        begin
            out_sample_reg <= SAMPLE_WIDTH'(y_out);
            clipped_reg    <= clip_reg | y_sat.clip | out_clip;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign clipped    = clipped_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `OZAP_ASSERT_IMP(a_round_drained, state_reg == S_ROUND,
        (tap_cnt_reg == TAP_COUNT) && !rd_pend_reg && !acc_en_reg,
        "rounding started before the mac drained")
    `OZAP_ASSERT_IMP(a_read_in_mac, rd_pend_reg,
        $past(state_reg) == S_GAIN || $past(state_reg) == S_TAPS,
        "history read outside the tap phase")
    `OZAP_ASSERT_IMP(a_out_from_round, $rose(out_valid_reg),
        $past(state_reg) == S_ROUND,
        "output word loaded outside the round step")
    `OZAP_ASSERT_ALWAYS(a_valid_grows,
        $countones(hist_vld_reg) >= $past($countones(hist_vld_reg)),
        "history valid bit lost")

endmodule

/* test/one_zero_all_pole_filter_core_tb.sv */
`timescale 1ns / 1ps

module one_zero_all_pole_filter_core_tb;

    localparam int SAMPLE_W        = ozap_pkg::SAMPLE_WIDTH_DEF;
    localparam int COEFF_W         = ozap_pkg::COEFF_WIDTH_DEF;
    localparam int ORDER           = ozap_pkg::FILTER_ORDER_DEF;
    localparam int CFG_IDX_W       = ozap_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = ozap_pkg::CFG_DATA_W;
    localparam int SLOT_W          = ozap_pkg::SLOT_W;
    localparam int MAX_TAPS        = ozap_pkg::MAX_TAPS;
    localparam int FRAC_BITS       = ozap_pkg::FRAC_BITS;
    localparam int HIST_W          = ozap_pkg::HIST_W;
    localparam int POLE_GAIN_W     = ozap_pkg::POLE_GAIN_W;
    localparam int ZERO_COEFF_W    = ozap_pkg::ZERO_COEFF_W;
    localparam int ONE_ZERO_GAIN_W = ozap_pkg::ONE_ZERO_GAIN_W;
    localparam int NUM_CFG_REGS  = 7;
    // only index left over in the 3-bit register space
    localparam logic [CFG_IDX_W-1:0] BAD_REG_IDX = 3'd7;
    localparam int RANDOM_WORDS  = 680;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [SLOT_W-1:0] SLOT_MAX = {1'b0, {(SLOT_W-1){1'b1}}};
    localparam logic [SLOT_W-1:0] SLOT_MIN = {1'b1, {(SLOT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip;
    } filtered_word_t;

    logic                           clk;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic signed [SAMPLE_W-1:0]     in_sample  = '0;
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0]     out_sample;
    logic                           clipped;
    logic                           cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]           cfg_index  = '0;
    logic [CFG_DATA_W-1:0]          cfg_wdata  = '0;

    // filter words still owed by the block, oldest first
    filtered_word_t filtered_q[$];
    filtered_word_t oldest;
    int fail_count = 0;

    // shadow copy of the register file and of the filter memory
    logic [CFG_DATA_W-1:0] shadow_reg [NUM_CFG_REGS];
    longint pole_mem [MAX_TAPS];
    longint last_scaled;

    // sender and receiver pacing knobs
    bit sender_bursts = 1'b0;
    int burst_left    = 0;
    bit rx_throttle   = 1'b0;
    int stall_left    = 0;
    int quiet_cycles  = 0;

    one_zero_all_pole_filter_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_sample  (in_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .clipped    (clipped),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor(v / 2^14 + 1/2)
    function automatic longint round_q14(input longint v);
        return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // clamp to a signed width, flag any clamping
    function automatic longint clamp_bits(input longint v, input int w, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // tap t lives in slot t%3 of coefficient register t/3
    function automatic longint pole_tap_coeff(input int t);
        logic [CFG_DATA_W-1:0]      r;
        logic signed [COEFF_W-1:0]  c;
        r = shadow_reg[t / 3];
        c = r[SLOT_W * (t % 3) +: COEFF_W];
        return c;
    endfunction

    // one sample through the one-zero stage and the all-pole stage
    function automatic filtered_word_t filter_sample(input logic signed [SAMPLE_W-1:0] x_in);
        filtered_word_t                 res;
        logic signed [POLE_GAIN_W-1:0]  pg_bits;
        logic signed [ZERO_COEFF_W-1:0] zc_bits;
        logic [ONE_ZERO_GAIN_W-1:0]     g_bits;
        longint x;
        longint g;
        longint zc;
        longint pg;
        longint scaled;
        longint oz;
        longint acc;
        longint y;
        bit     hit;
        int     i;
        hit     = 1'b0;
        pg_bits = shadow_reg[ozap_pkg::REG_POLE_GAIN][POLE_GAIN_W-1:0];
        zc_bits = shadow_reg[ozap_pkg::REG_ZERO_COEFF][ZERO_COEFF_W-1:0];
        g_bits  = shadow_reg[ozap_pkg::REG_ONE_ZERO_GAIN][ONE_ZERO_GAIN_W-1:0];
        x  = x_in;
        g  = g_bits;
        zc = zc_bits;
        pg = pg_bits;
        // one-zero stage, gain above one is taken as is
        scaled = clamp_bits(round_q14(x * g), HIST_W, hit);
        oz = clamp_bits(round_q14(last_scaled * zc) + scaled, HIST_W, hit);
        last_scaled = scaled;
        // all-pole stage
        acc = oz * pg;
        for (i = 0; i < ORDER; i++)
            acc -= pole_mem[i] * pole_tap_coeff(i);
        y = clamp_bits(round_q14(acc), HIST_W, hit);
        for (i = ORDER - 1; i > 0; i--)
            pole_mem[i] = pole_mem[i - 1];
        pole_mem[0] = y;
        y = clamp_bits(y, SAMPLE_W, hit);
        res.sample = y[SAMPLE_W-1:0];
        res.clip   = hit;
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return SAMPLE_W'($urandom_range(0, 4095)) - SAMPLE_W'(2048);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // three slots: all zero, small and stable, or anything at all
    function automatic logic [CFG_DATA_W-1:0] random_coeff_reg(input int spread);
        logic [CFG_DATA_W-1:0] r;
        logic [SLOT_W-1:0]     slot;
        int k;
        for (k = 0; k < 3; k++)
        begin
            if (spread == 0)
                slot = '0;
            else if (spread < 5)
                slot = SLOT_W'($urandom_range(0, 2047)) - SLOT_W'(1024);
            else
                slot = SLOT_W'($urandom);
            r[SLOT_W * k +: SLOT_W] = slot;
        end
        return r;
    endfunction

    // hand one word to the block, pacing it in bursts when asked
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        if (sender_bursts && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        filtered_q.push_back(filter_sample(s));
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic sender_idle();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (filtered_q.size() != 0)
            @(posedge clk);
    endtask

    // write every register once the block has gone quiet; bits above the width of the
    // gain and zero registers carry junk, and a stray write hits the unused index
    task automatic apply_filter_config(
        input logic [CFG_DATA_W-1:0]          c0,
        input logic [CFG_DATA_W-1:0]          c1,
        input logic [CFG_DATA_W-1:0]          c2,
        input logic [CFG_DATA_W-1:0]          c3,
        input logic signed [POLE_GAIN_W-1:0]  pg,
        input logic signed [ZERO_COEFF_W-1:0] zc,
        input logic [ONE_ZERO_GAIN_W-1:0]     g
    );
        logic [CFG_DATA_W-1:0] word [NUM_CFG_REGS];
        logic [63:0]           junk;
        int i;
        junk = {$urandom, $urandom};
        word[ozap_pkg::REG_POLE_0_2]      = c0;
        word[ozap_pkg::REG_POLE_3_5]      = c1;
        word[ozap_pkg::REG_POLE_6_8]      = c2;
        word[ozap_pkg::REG_POLE_9_11]     = c3;
        word[ozap_pkg::REG_POLE_GAIN]     = {junk[CFG_DATA_W-POLE_GAIN_W-1:0], pg};
        word[ozap_pkg::REG_ZERO_COEFF]    = {junk[CFG_DATA_W-ZERO_COEFF_W-1:0], zc};
        word[ozap_pkg::REG_ONE_ZERO_GAIN] = {junk[CFG_DATA_W-ONE_ZERO_GAIN_W-1:0], g};
        sender_idle();
        wait_drained();
        for (i = 0; i < NUM_CFG_REGS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ozap_pkg::cfg_idx_t'(i);
            cfg_wdata <= word[i];
            @(posedge clk);
            shadow_reg[i] = word[i];
        end
        // must leave every register untouched
        cfg_index <= BAD_REG_IDX;
        cfg_wdata <= junk[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // register defaults straight out of reset: no feedback, unity pole gain
    task automatic test_reset_state();
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(-1);
        send_sample(1);
    endtask

    // gain extremes, zero gain, and feedback hard enough to saturate the memory
    task automatic test_gain_extremes();
        apply_filter_config('0, '0, '0, '0, {1'b0, {(POLE_GAIN_W-1){1'b1}}},
                            {1'b0, {(ZERO_COEFF_W-1){1'b1}}}, {ONE_ZERO_GAIN_W{1'b1}});
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);

        apply_filter_config('0, '0, '0, '0, {1'b1, {(POLE_GAIN_W-1){1'b0}}},
                            {1'b1, {(ZERO_COEFF_W-1){1'b0}}}, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);

        // most negative coefficient on every tap, impulse then silence
        apply_filter_config({3{SLOT_MIN}}, {3{SLOT_MIN}}, {3{SLOT_MIN}}, {3{SLOT_MIN}},
                            ozap_pkg::POLE_GAIN_RST, '0, 15'd16384);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample('0);
        send_sample('0);

        // most positive coefficient on every tap
        apply_filter_config({3{SLOT_MAX}}, {3{SLOT_MAX}}, {3{SLOT_MAX}}, {3{SLOT_MAX}},
                            ozap_pkg::POLE_GAIN_RST, ozap_pkg::ZERO_COEFF_RST,
                            ozap_pkg::ONE_ZERO_GAIN_RST);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(SAMPLE_MIN);
    endtask

    // phases of random settings with random words, pacing varied per phase
    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0]          c [4];
        logic signed [POLE_GAIN_W-1:0]  pg;
        logic signed [ZERO_COEFF_W-1:0] zc;
        logic [ONE_ZERO_GAIN_W-1:0]     g;
        int sent;
        int phase;
        int len;
        int n;
        int spread;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            spread = $urandom_range(0, 5);
            for (n = 0; n < 4; n++)
                c[n] = random_coeff_reg(spread);
            if ($urandom_range(0, 3) == 0)
                pg = POLE_GAIN_W'($urandom);
            else
                pg = POLE_GAIN_W'($urandom_range(0, 32768)) - POLE_GAIN_W'(16384);
            if ($urandom_range(0, 2) == 0)
                zc = ZERO_COEFF_W'($urandom);
            else
                zc = ZERO_COEFF_W'($urandom_range(0, 32768)) - ZERO_COEFF_W'(16384);
            if ($urandom_range(0, 3) == 0)
                g = ONE_ZERO_GAIN_W'($urandom);
            else
                g = ONE_ZERO_GAIN_W'($urandom_range(0, 16384));
            apply_filter_config(c[0], c[1], c[2], c[3], pg, zc, g);

            sender_bursts = ($urandom_range(0, 3) != 0);
            rx_throttle   = ($urandom_range(0, 3) != 0);
            burst_left    = 0;
            len = $urandom_range(30, 120);
            if (len > RANDOM_WORDS - sent)
                len = RANDOM_WORDS - sent;
            for (n = 0; n < len; n++)
            begin
                // hold off until the block has handed back everything
                if (n == len / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
                begin
                    sender_idle();
                    wait_drained();
                end
                send_sample(random_sample());
            end
            sent += len;
            phase++;
        end
    endtask

    // receiver backpressure: runs of stall and ready of random length
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (out_stall)
        begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end
        else if (rx_throttle)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
    end

    // compare each word taken from the block with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (filtered_q.size() == 0)
            begin
                fail_count++;
                $error("word with none owed: out_sample %0d clipped %0b",
                       out_sample, clipped);
            end
            else
            begin
                oldest = filtered_q.pop_front();
                if (out_sample !== oldest.sample)
                begin
                    fail_count++;
                    $error("out_sample: expected %0d, got %0d", oldest.sample, out_sample);
                end
                if (clipped !== oldest.clip)
                begin
                    fail_count++;
                    $error("clipped: expected %0b, got %0b", oldest.clip, clipped);
                end
            end
        end
    end

    // give up once nothing has moved on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("one_zero_all_pole_filter_core_tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int i;
        // shadow state matches the block's reset
        for (i = 0; i < NUM_CFG_REGS; i++)
            shadow_reg[i] = '0;
        shadow_reg[ozap_pkg::REG_POLE_GAIN]     = CFG_DATA_W'(ozap_pkg::POLE_GAIN_RST);
        shadow_reg[ozap_pkg::REG_ZERO_COEFF]    = CFG_DATA_W'(ozap_pkg::ZERO_COEFF_RST);
        shadow_reg[ozap_pkg::REG_ONE_ZERO_GAIN] = CFG_DATA_W'(ozap_pkg::ONE_ZERO_GAIN_RST);
        for (i = 0; i < MAX_TAPS; i++)
            pole_mem[i] = 0;
        last_scaled = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_gain_extremes();
        test_random_phases();

        // let the pipe empty, then a little longer for any stray word
        sender_idle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (filtered_q.size() != 0)
        begin
            fail_count++;
            $error("%0d filtered words never arrived", filtered_q.size());
        end

        if (fail_count == 0)
            $display("one_zero_all_pole_filter_core_tb: done, clean");
        else
            $display("one_zero_all_pole_filter_core_tb: done, errors");
        $finish;
    end

endmodule
